### hdl/bpb_pkg.sv
package bpb_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned PROD_W    = 2 * CHAN_W;
  localparam int unsigned ALPHA_LSB = NUM_LANES * CHAN_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_MUL     = 2'd2,
    MODE_ALPHA   = 2'd3
  } blend_mode_t;

  // per-lane control from the pipeline controller
  typedef struct packed {
    logic        load;
    blend_mode_t mode_in;
    blend_mode_t mode_s1;
  } lane_ctl_t;

  // floor(x / 255), exact while the quotient fits a byte (x below 65280)
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = (PROD_W+1)'(x) + (PROD_W+1)'(x[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
    return t[PROD_W-1:CHAN_W];
  endfunction

endpackage

### hdl/bpb_in_if.sv
interface bpb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] dest_pixel;
  logic [31:0] src_pixel;

  modport source (output valid, output mode, output dest_pixel, output src_pixel,
                  input ready);
  modport sink   (input valid, input mode, input dest_pixel, input src_pixel,
                  output ready);
endinterface

### hdl/bpb_out_if.sv
interface bpb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;

  modport source (output valid, output result_pixel, input ready);
  modport sink   (input valid, input result_pixel, output ready);
endinterface

### hdl/bpb_lane.sv
module bpb_lane (
  input  logic                          clk,
  input  bpb_pkg::lane_ctl_t            ctl,
  input  logic [bpb_pkg::CHAN_W-1:0]    d_chan,
  input  logic [bpb_pkg::CHAN_W-1:0]    s_chan,
  input  logic [bpb_pkg::CHAN_W-1:0]    a_chan,
  output logic [bpb_pkg::CHAN_W-1:0]    res_chan
);
  import bpb_pkg::*;

  logic [PROD_W-1:0] num_r;
  logic [PROD_W-1:0] num_nxt;

  // stage 1: sum or weighted products
  always_comb begin
    case (ctl.mode_in)
      MODE_ADD:   num_nxt = PROD_W'(d_chan) + PROD_W'(s_chan);
      MODE_MUL:   num_nxt = PROD_W'(d_chan) * PROD_W'(s_chan);
      MODE_ALPHA: num_nxt = PROD_W'(CHAN_MAX - a_chan) * PROD_W'(d_chan)
                          + PROD_W'(a_chan) * PROD_W'(s_chan);
      default:    num_nxt = PROD_W'(s_chan);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      num_r <= num_nxt;
    end
  end

  // stage 2: saturate or scale back by 1/255
  always_comb begin
    case (ctl.mode_s1)
      MODE_ADD:   res_chan = (num_r > PROD_W'(CHAN_MAX)) ? CHAN_MAX : num_r[CHAN_W-1:0];
      MODE_MUL,
      MODE_ALPHA: res_chan = div255(num_r);
      default:    res_chan = num_r[CHAN_W-1:0];
    endcase
  end

endmodule

### hdl/bgra_pixel_blend_unit.sv
// bgra pixel blend unit
// in_ch carries one request per pixel pair: a 2-bit blend mode, the
// destination pixel and the source pixel, both bgra8888 (blue in bits 7:0,
// alpha in bits 31:24). out_ch returns one blended pixel per request, in
// request order.
// modes: replace copies the source, add saturates each color byte at 255,
// multiply gives d*s/255 and alpha gives ((255-a)*d + a*s)/255 with the
// source alpha a; the blend modes keep the destination alpha byte.
// a request passes from acceptance to out_ch.valid through one product stage
// in three color lanes, then the divide-by-255 and byte merge into the
// output register. one request is taken every cycle while out_ch drains.
// reset (rst_n low, synchronous) empties both stages; in_ch.ready is low
// while reset is held.
// when the receiver stalls, the output register holds its pixel and the
// product stage still takes one more request, so ready drops only once
// both stages are full.
module bgra_pixel_blend_unit (
  input  logic      clk,
  input  logic      rst_n,
  bpb_in_if.sink    in_ch,
  bpb_out_if.source out_ch
);
  import bpb_pkg::*;

  // pipeline occupancy
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s2_ready, s1_ready;
  logic in_acc, s1_move;

  // side-band carried next to the lanes
  blend_mode_t       mode_in;
  blend_mode_t       mode_s1_r;
  logic [CHAN_W-1:0] dest_a_s1_r;
  logic [CHAN_W-1:0] src_a_s1_r;
  logic [CHAN_W-1:0] src_a_in;

  logic [PIXEL_W-1:0] merged;
  logic [PIXEL_W-1:0] out_pixel_r;
  lane_ctl_t          lane_ctl;

  assign mode_in  = blend_mode_t'(in_ch.mode);
  assign src_a_in = in_ch.src_pixel[ALPHA_LSB +: CHAN_W];

  // output stage frees up when empty or being taken
  assign s2_ready = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ch.ready = rst_n && s1_ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign s1_move  = s1_valid_r && s2_ready;

  assign lane_ctl.load    = in_acc;
  assign lane_ctl.mode_in = mode_in;
  assign lane_ctl.mode_s1 = mode_s1_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_acc;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // alpha bytes and mode ride alongside the lane product registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_s1_r   <= mode_in;
      dest_a_s1_r <= in_ch.dest_pixel[ALPHA_LSB +: CHAN_W];
      src_a_s1_r  <= src_a_in;
    end
  end

  // one lane per color byte: blue, green, red
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    bpb_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .d_chan   (in_ch.dest_pixel[k*CHAN_W +: CHAN_W]),
      .s_chan   (in_ch.src_pixel[k*CHAN_W +: CHAN_W]),
      .a_chan   (src_a_in),
      .res_chan (merged[k*CHAN_W +: CHAN_W])
    );
  end

  // merge: alpha byte from source on replace, else from destination
  assign merged[ALPHA_LSB +: CHAN_W] =
    (mode_s1_r == MODE_REPLACE) ? src_a_s1_r : dest_a_s1_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pixel_r <= merged;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_pixel = out_pixel_r;

endmodule

### hdl/bpb_checker.sv
module bpb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_pixel
);

  // a result can only appear after some request was taken and passed the product stage
  a_rise_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a request two cycles earlier");

  // back-pressure only when both stages hold data and the receiver stalls
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the pipeline can drain");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_pixel)))
    else $error("stalled result changed or dropped");

endmodule

bind bgra_pixel_blend_unit bpb_checker u_bpb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_pixel (out_ch.result_pixel)
);
